/* design/lqse_pkg.sv */
// Package: operation and status codes and word types for the linear queue core.
`timescale 1ns / 1ps
package lqse_pkg;

  localparam int unsigned DATA_W = 32;

  // Operation codes carried in the command word
  localparam logic [2:0] FUNC_ENQ  = 3'd0;
  localparam logic [2:0] FUNC_DEQ  = 3'd1;
  localparam logic [2:0] FUNC_SRCH = 3'd2;
  localparam logic [2:0] FUNC_EDIT = 3'd3;
  localparam logic [2:0] FUNC_TRAV = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] data_in;
    logic signed [DATA_W-1:0] new_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic                     last;
  } res_t;

  // Per-cell control: rotate the ring, and replace the word entering the cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

/* design/linear_queue_with_search_edit_core.sv */
// Top level: array-backed linear queue with search, edit and traverse over a ring of cells.
`timescale 1ns / 1ps
// Timing: a rejected command (queue empty, queue full) answers in the cycle after start.
// Every other command rotates the ring once round, one entry passing the read cell each
// cycle; each result is registered and appears in the cycle after its entry passes. A
// new command is taken only once that rotation is done and busy has fallen.
// Reset (rst, synchronous) empties the queue and drops any command in flight; entry
// contents are left as they were. Results are strobed for one cycle; the receiver cannot stall.
module linear_queue_with_search_edit_core
  import lqse_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic valid,
  output res_t res
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);

  // Ring of cells: cell i hands its word to cell i-1 each scan cycle, cell 0 wraps
  // round to the top cell. The top cell is where a new or edited word enters.
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  cell_ctl_t                cell_ctl [DEPTH];
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_value;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign cell_ctl[gi].shift = busy;
      assign cell_ctl[gi].load  = (gi == DEPTH - 1) ? wr_en : 1'b0;
      lqse_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[gi]),
        .shift_in   (cell_q[(gi + 1) % DEPTH]),
        .load_value (wr_value),
        .value      (cell_q[gi])
      );
    end
  endgenerate

  // Queue state and the command being worked on
  logic [IW-1:0]            head;
  logic [IW-1:0]            tail;
  logic                     empty;
  logic [IW-1:0]            step;
  logic [2:0]               op;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] repl;
  logic                     hit;

  logic signed [DATA_W-1:0] cur;
  logic                     in_range;
  logic                     match;
  logic                     at_enq_slot;

  assign cur         = cell_q[0];  // at scan step k the read cell holds entry k
  assign in_range    = !empty && (step >= head) && (step <= tail);
  assign match       = in_range && !hit && (cur == key);
  assign at_enq_slot = empty ? (step == '0)
                             : ({1'b0, step} == ({1'b0, tail} + (IW + 1)'(1)));

  // Decide what happens to the word leaving the read cell this cycle
  always_comb begin
    wr_en    = 1'b0;
    wr_value = key;
    case (op)
      FUNC_ENQ: begin
        wr_en    = busy && !hit && at_enq_slot;
        wr_value = key;
      end
      FUNC_EDIT: begin
        wr_en    = busy && match;
        wr_value = repl;
      end
      default: begin
        wr_en    = 1'b0;
        wr_value = key;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
      step  <= '0;
      hit   <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (!busy) begin
        if (start && (cmd.func <= FUNC_TRAV)) begin
          op   <= cmd.func;
          key  <= cmd.data_in;
          repl <= cmd.new_value;
          step <= '0;
          hit  <= 1'b0;
          if ((cmd.func != FUNC_ENQ) && empty) begin
            // Nothing stored: answer at once
            valid        <= 1'b1;
            res.status   <= ST_EMPTY;
            res.data_out <= '0;
            res.last     <= 1'b1;
          end else if ((cmd.func == FUNC_ENQ) && !empty && (tail == LAST_STEP)) begin
            valid        <= 1'b1;
            res.status   <= ST_FULL;
            res.data_out <= '0;
            res.last     <= 1'b1;
          end else begin
            busy <= 1'b1;
          end
        end
      end else begin
        // One scan step: the ring advances, step counts entries past the read cell
        step <= step + IW'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
        case (op)
          FUNC_ENQ: begin
            if (!hit && at_enq_slot) begin
              hit          <= 1'b1;
              valid        <= 1'b1;
              res.status   <= ST_OK;
              res.data_out <= '0;
              res.last     <= 1'b1;
              if (empty) begin
                head  <= '0;
                tail  <= '0;
                empty <= 1'b0;
              end else begin
                tail <= tail + IW'(1);
              end
            end
          end
          FUNC_DEQ: begin
            if (!hit && (step == head)) begin
              hit          <= 1'b1;
              valid        <= 1'b1;
              res.status   <= ST_OK;
              res.data_out <= cur;
              res.last     <= 1'b1;
              if (head == tail) begin
                // Drained: reclaim every slot
                head  <= '0;
                tail  <= '0;
                empty <= 1'b1;
              end else begin
                head <= head + IW'(1);
              end
            end
          end
          FUNC_SRCH, FUNC_EDIT: begin
            if (match) begin
              hit          <= 1'b1;
              valid        <= 1'b1;
              res.status   <= ST_OK;
              res.data_out <= (op == FUNC_EDIT) ? repl : cur;
              res.last     <= 1'b1;
            end else if (!hit && (step == LAST_STEP)) begin
              valid        <= 1'b1;
              res.status   <= ST_MISSING;
              res.data_out <= '0;
              res.last     <= 1'b1;
            end
          end
          FUNC_TRAV: begin
            if (in_range) begin
              valid        <= 1'b1;
              res.status   <= ST_OK;
              res.data_out <= cur;
              res.last     <= (step == tail);
            end
          end
          default: begin
            hit <= hit;
          end
        endcase
      end
    end
  end

endmodule

/* design/lqse_cell.sv */
// Module: one storage cell of the rotating entry ring.
`timescale 1ns / 1ps
module lqse_cell
  import lqse_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] shift_in,
  input  logic signed [DATA_W-1:0] load_value,
  output logic signed [DATA_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= ctl.load ? load_value : shift_in;
    end
  end

endmodule
